// File: src/assert_macros.svh
// Assertion macros used by the checker of this block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check with a message.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when the antecedent holds, the consequent must hold the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dtpc_pkg.sv
// Package for the distance-threshold point clustering block.
// Holds sizes, payload structs and the controller/datapath interface structs; no dependencies.
`timescale 1ns / 1ps

package dtpc_pkg;

  localparam int MAX_POINTS = 256;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ID_W       = 9;
  localparam int COORD_W    = 16;
  localparam int SENSOR_W   = 8;
  localparam int LIMIT_W    = 35;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [SENSOR_W-1:0]        sensor_num;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] cluster_id;
    logic            opened_new;
    logic            store_full;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             idle;
    logic             load_item;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             finish;
  } dtpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             item_clear;
    logic             store_full;
    logic [CNT_W-1:0] point_count;
    logic             pipe_busy;
    logic             out_free;
  } dtpc_stat_t;

endpackage

// File: src/dtpc_datapath.sv
// Datapath: point store, distance pipeline, best-cluster search, counters and result register.
// Depends on dtpc_pkg; driven by dtpc_ctrl through dtpc_cmd_t.
`timescale 1ns / 1ps

module dtpc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtpc_pkg::in_item_t    in_data,
  input  logic                  cfg_wr_en,
  input  logic [dtpc_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  dtpc_pkg::dtpc_cmd_t   cmd,
  output dtpc_pkg::dtpc_stat_t  stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dtpc_pkg::out_item_t   out_data
);
  import dtpc_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [ID_W-1:0]     cluster;
    logic [SENSOR_W-1:0] sensor;
  } point_entry_t;

  point_entry_t mem [MAX_POINTS];
  point_entry_t rd_data_r;

  logic [LIMIT_W-1:0] limit_r;
  in_item_t           item_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]    next_id_r, next_id_nxt, next_id_inc;

  logic                  v1_r, v2_r, v3_r;
  logic signed [COORD_W:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [ID_W-1:0]       cl2_r, cl3_r;
  logic signed [2*COORD_W+1:0] prod_x, prod_y;
  logic [2*COORD_W-1:0]  sqx_r, sqy_r;
  logic [2*COORD_W:0]    dist_sum;
  logic                  hit;

  logic [ID_W-1:0] best_r, best_nxt;
  logic            found_r, found_nxt;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       full;

  assign full = (count_r == CNT_W'(MAX_POINTS));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // Point store: one write port at finish, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.finish && item_r.cmd == CMD_ADD && !full) begin
      mem[count_r[PTR_W-1:0]] <= '{x: item_r.pos_x, y: item_r.pos_y,
                                   cluster: out_nxt.cluster_id,
                                   sensor: item_r.sensor_num};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Distance pipeline: difference, square, then sum and compare.
  assign dx_nxt = $signed({item_r.pos_x[COORD_W-1], item_r.pos_x})
                - $signed({rd_data_r.x[COORD_W-1], rd_data_r.x});
  assign dy_nxt = $signed({item_r.pos_y[COORD_W-1], item_r.pos_y})
                - $signed({rd_data_r.y[COORD_W-1], rd_data_r.y});
  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign hit = v3_r && ({{(LIMIT_W-2*COORD_W-1){1'b0}}, dist_sum} <= limit_r);

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    cl2_r <= rd_data_r.cluster;
    sqx_r <= prod_x[2*COORD_W-1:0];
    sqy_r <= prod_y[2*COORD_W-1:0];
    cl3_r <= cl2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Smallest id among in-range stored points.
  always_comb begin
    best_nxt  = best_r;
    found_nxt = found_r;
    if (cmd.load_item) begin
      found_nxt = 1'b0;
    end else if (hit && (!found_r || cl3_r < best_r)) begin
      best_nxt  = cl3_r;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_r <= best_nxt;
  end

  // Result and counter updates at finish. Ids skip zero when they wrap.
  assign next_id_inc = next_id_r + ID_W'(1);

  always_comb begin
    out_nxt       = '0;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (item_r.cmd == CMD_CLEAR) begin
        count_nxt   = '0;
        next_id_nxt = ID_W'(1);
      end else if (full) begin
        out_nxt.store_full = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (found_r) begin
          out_nxt.cluster_id = best_r;
        end else begin
          out_nxt.cluster_id = next_id_r;
          out_nxt.opened_new = 1'b1;
          next_id_nxt = (next_id_inc == '0) ? ID_W'(1) : next_id_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.item_clear  = (item_r.cmd == CMD_CLEAR);
  assign stat.store_full  = full;
  assign stat.point_count = count_r;
  assign stat.pipe_busy   = v1_r || v2_r || v3_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

endmodule

// File: src/dtpc_ctrl.sv
// Controller state machine: accepts an item, sequences the store scan and the finish step.
// Depends on dtpc_pkg; talks to dtpc_datapath only through dtpc_cmd_t and dtpc_stat_t.
`timescale 1ns / 1ps

module dtpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  dtpc_pkg::dtpc_stat_t stat,
  output dtpc_pkg::dtpc_cmd_t  cmd
);
  import dtpc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic             last_idx;

  assign last_idx = (CNT_W'(idx_r) + CNT_W'(1) == stat.point_count);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.rd_addr   = idx_r;
    case (state_r)
      ST_IDLE: begin
        cmd.idle      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        idx_nxt = '0;
        if (stat.item_clear || stat.store_full || stat.point_count == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (last_idx) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: src/distance_threshold_point_clustering.sv
// Top level of the distance-threshold point clustering block.
// Depends on dtpc_pkg, dtpc_ctrl and dtpc_datapath.
//
// Usage. Each input transfer carries a command, an object position (x, y in signed
// Q8.8 metres) and a sensor number. An add to a store that is not full compares the point
// with every stored point; it joins the lowest-numbered cluster that holds a point whose
// squared distance is at or below the configured limit, or else opens a new cluster. The
// point is then stored. A clear command empties the store and restarts cluster ids at 1.
// Every input transfer produces exactly one output transfer.
// Sequencing. An add to a store that is neither empty nor full scans every stored point
// through the single read port of the point memory, which is visited one entry per cycle,
// followed by a short subtract/square/compare pipeline; a clear, an add to an empty store
// or an add to a full store skips the scan. One item is worked on at a time: in_stall is
// high from acceptance until the result has been loaded into the output register, and only
// then can the next transfer follow.
// Stalls. A result waits in the output register while out_stall is high, and the next
// item may already be accepted and scanned meanwhile; its own result is held back until
// the register frees up. Reset (rst_n low at a clock edge) empties the store, sets the
// next id to 1, drops any pending result and restores the limit to 4.0 m squared.
`timescale 1ns / 1ps

module distance_threshold_point_clustering (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dtpc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtpc_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [dtpc_pkg::LIMIT_W-1:0]  cfg_wr_data
);
  import dtpc_pkg::*;

  dtpc_cmd_t  cmd;
  dtpc_stat_t stat;

  // The controller decides when items are taken and when the memory is scanned.
  dtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the store, the limit register, the counters and the result.
  dtpc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // An input transfer is possible only while the controller sits idle.
  assign in_stall = !cmd.idle;

endmodule

// File: src/dtpc_checker.sv
// Port-level checker for the distance-threshold point clustering block, with its bind.
// Depends on dtpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input dtpc_pkg::out_item_t           out_data
);
  import dtpc_pkg::*;

  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block took a second item at once")
  `ASSERT_IMPLY(a_new_not_full, out_valid, !(out_data.opened_new && out_data.store_full), "new cluster on a full store")
  `ASSERT_IMPLY(a_new_id_nonzero, out_valid && out_data.opened_new, out_data.cluster_id != '0, "new cluster got id zero")
  `ASSERT_IMPLY(a_full_id_zero, out_valid && out_data.store_full, out_data.cluster_id == '0, "dropped point carries an id")
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind distance_threshold_point_clustering dtpc_checker u_dtpc_checker (.*);
